@@ hdl/ibwt_pkg.sv @@
package ibwt_pkg;

  localparam int NUM_SYM  = 257;
  localparam int SYM_W    = 9;
  localparam logic [SYM_W-1:0] SENT_SYM = 9'd256;

  typedef enum logic [1:0] {
    REQ_HDR   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_DRAIN = 2'd2,
    REQ_RSVD  = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_HDR = 2'd2,
    ST_OVFL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] primary_index;
    logic [11:0] sentinel_pos;
    logic [7:0]  data_byte;
    logic        end_of_block;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [11:0] out_position;
    logic        last_of_run;
    logic [1:0]  status;
  } out_rsp_t;

endpackage

@@ hdl/inverse_bwt_lf_decoder_core.sv @@
// Channel   Ports                      Direction  Handshake
// request   start, busy, in_data       in         taken when start & !busy
// result    out_valid, out_data        out        one-cycle strobe, no stall
//
// Header: taken while idle. Data byte: count read, count write back; a byte
// dropped on overflow is not stored and sets the overflow flag. Last data
// byte adds the table build: prefix sums, a link pass per stored byte, a
// closing step. Drain: result after link read and block read; error or empty
// drains answer the cycle after the request. Reset (rst_n, sync) clears
// control state and the count valid bits; memories need no clearing.
module inverse_bwt_lf_decoder_core
  import ibwt_pkg::*;
#(
  parameter int BLOCK_MAX = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_rsp_t out_data
);

  localparam int AW = $clog2(BLOCK_MAX);
  localparam int CW = $clog2(BLOCK_MAX + 1);
  localparam int SW = SYM_W + 1;   // prefix index runs to 257

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CNT  = 8'b0000_0010,
    S_PFX  = 8'b0000_0100,
    S_LK0  = 8'b0000_1000,
    S_LK1  = 8'b0001_0000,
    S_LK2  = 8'b0010_0000,
    S_DR1  = 8'b0100_0000,
    S_DR2  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]    loaded_r, loaded_nxt;
  logic [11:0]      start_row_r, start_row_nxt;
  logic [11:0]      sent_r, sent_nxt;
  logic [AW-1:0]    walk_r, walk_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [1:0]       flags_r, flags_nxt;   // bit0 bad header, bit1 overflow
  logic [NUM_SYM-1:0] cvld_r, cvld_nxt;   // count entry written since header
  logic             cvld_rd_r;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             eob_r, eob_nxt;
  logic [SW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    acc_r, acc_nxt;
  logic [CW-1:0]    lidx_r, lidx_nxt;
  logic             ov_r, ov_nxt;
  out_rsp_t         out_r, out_nxt;

  // memory ports
  logic             blk_we;
  logic [AW-1:0]    blk_waddr, blk_raddr;
  logic [7:0]       blk_rdata;
  logic             lnk_we;
  logic [AW-1:0]    lnk_waddr;
  logic [AW-1:0]    lnk_rdata;
  logic             cnt_we;
  logic [SYM_W-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0]    cnt_wdata, cnt_rdata, cnt_val;
  logic             sts_we;
  logic [SYM_W-1:0] sts_waddr, sts_raddr;
  logic [CW-1:0]    sts_wdata, sts_rdata;

  logic             accept;
  logic [SYM_W-1:0] in_sym, lk_sym;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign cnt_val  = cvld_rd_r ? cnt_rdata : '0;

  // symbol of the incoming byte at the next load position
  assign in_sym = (32'(loaded_r) == 32'(sent_r)) ? SENT_SYM : {1'b0, in_data.data_byte};
  assign lk_sym = (32'(lidx_r) == 32'(sent_r)) ? SENT_SYM : {1'b0, blk_rdata};

  ibwt_ram #(.WIDTH(8), .DEPTH(BLOCK_MAX)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(in_data.data_byte),
    .raddr(blk_raddr), .rdata(blk_rdata));

  ibwt_ram #(.WIDTH(AW), .DEPTH(BLOCK_MAX)) u_lnk (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(AW'(sts_rdata)),
    .raddr(walk_r), .rdata(lnk_rdata));

  ibwt_ram #(.WIDTH(CW), .DEPTH(NUM_SYM)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));

  ibwt_ram #(.WIDTH(CW), .DEPTH(NUM_SYM)) u_sts (
    .clk(clk), .we(sts_we), .waddr(sts_waddr), .wdata(sts_wdata),
    .raddr(sts_raddr), .rdata(sts_rdata));

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    start_row_nxt = start_row_r;
    sent_nxt      = sent_r;
    walk_nxt      = walk_r;
    rem_nxt       = rem_r;
    flags_nxt     = flags_r;
    cvld_nxt      = cvld_r;
    sym_nxt       = sym_r;
    eob_nxt       = eob_r;
    pidx_nxt      = pidx_r;
    acc_nxt       = acc_r;
    lidx_nxt      = lidx_r;
    ov_nxt        = 1'b0;
    out_nxt       = out_r;

    blk_we    = 1'b0;
    blk_waddr = loaded_r[AW-1:0];
    blk_raddr = lidx_r[AW-1:0];
    lnk_we    = 1'b0;
    lnk_waddr = lidx_r[AW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = sym_r;
    cnt_wdata = cnt_val + CW'(1);
    cnt_raddr = in_sym;
    sts_we    = 1'b0;
    sts_waddr = sym_r;
    sts_wdata = sts_rdata + CW'(1);
    sts_raddr = lk_sym;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req_code_t'(in_data.req_type))
            REQ_HDR: begin
              start_row_nxt = in_data.primary_index;
              sent_nxt      = in_data.sentinel_pos;
              cvld_nxt      = '0;
              loaded_nxt    = '0;
              walk_nxt      = '0;
              rem_nxt       = '0;
              flags_nxt     = '0;
            end
            REQ_DATA: begin
              eob_nxt = in_data.end_of_block;
              if (32'(loaded_r) < 32'(BLOCK_MAX)) begin
                blk_we     = 1'b1;
                sym_nxt    = in_sym;
                loaded_nxt = loaded_r + CW'(1);
                state_nxt  = S_CNT;
              end else begin
                flags_nxt[1] = 1'b1;
                if (in_data.end_of_block) begin
                  pidx_nxt  = '0;
                  acc_nxt   = '0;
                  state_nxt = S_PFX;
                end
              end
            end
            REQ_DRAIN: begin
              out_nxt = '0;
              priority if (flags_r[1]) begin
                ov_nxt = 1'b1;
                out_nxt.status = ST_OVFL;
              end else if (flags_r[0]) begin
                ov_nxt = 1'b1;
                out_nxt.status = ST_BAD_HDR;
              end else if (rem_r == '0) begin
                ov_nxt = 1'b1;
                out_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_DR1;   // link read of walk_r in flight
              end
            end
            REQ_RSVD: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_CNT: begin
        cnt_we          = 1'b1;
        cvld_nxt[sym_r] = 1'b1;
        if (eob_r) begin
          pidx_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = S_PFX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PFX: begin
        // read count[p] while writing start[p-1] from the previous read
        cnt_raddr = pidx_r[SYM_W-1:0];
        if (pidx_r != '0) begin
          sts_we    = 1'b1;
          sts_waddr = SYM_W'(pidx_r - SW'(1));
          sts_wdata = acc_r;
          acc_nxt   = acc_r + cnt_val;
        end
        pidx_nxt = pidx_r + SW'(1);
        if (32'(pidx_r) == NUM_SYM) begin
          lidx_nxt  = '0;
          state_nxt = S_LK0;
        end
      end
      S_LK0: begin
        if (lidx_r == loaded_r) begin
          state_nxt = S_IDLE;
          if (32'(start_row_r) >= 32'(loaded_r)) begin
            flags_nxt[0] = 1'b1;
            rem_nxt      = '0;
            walk_nxt     = '0;
          end else begin
            flags_nxt[0] = 1'b0;
            rem_nxt      = loaded_r - CW'(1);
          end
        end else begin
          state_nxt = S_LK1;   // block read of lidx in flight
        end
      end
      S_LK1: begin
        sym_nxt   = lk_sym;
        state_nxt = S_LK2;
      end
      S_LK2: begin
        lnk_we = 1'b1;
        sts_we = 1'b1;
        if (32'(lidx_r) == 32'(start_row_r)) begin
          walk_nxt = AW'(sts_rdata);
        end
        lidx_nxt  = lidx_r + CW'(1);
        state_nxt = S_LK0;
      end
      S_DR1: begin
        walk_nxt  = lnk_rdata;
        blk_raddr = lnk_rdata;
        rem_nxt   = rem_r - CW'(1);
        state_nxt = S_DR2;
      end
      S_DR2: begin
        ov_nxt               = 1'b1;
        out_nxt.out_byte     = blk_rdata;
        out_nxt.out_position = 12'(rem_r);
        out_nxt.last_of_run  = (rem_r == '0);
        out_nxt.status       = ST_OK;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      start_row_r <= '0;
      sent_r      <= '0;
      walk_r      <= '0;
      rem_r       <= '0;
      flags_r     <= '0;
      cvld_r      <= '0;
      ov_r        <= 1'b0;
      eob_r       <= 1'b0;
      pidx_r      <= '0;
      lidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      start_row_r <= start_row_nxt;
      sent_r      <= sent_nxt;
      walk_r      <= walk_nxt;
      rem_r       <= rem_nxt;
      flags_r     <= flags_nxt;
      cvld_r      <= cvld_nxt;
      ov_r        <= ov_nxt;
      eob_r       <= eob_nxt;
      pidx_r      <= pidx_nxt;
      lidx_r      <= lidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    acc_r     <= acc_nxt;
    out_r     <= out_nxt;
    cvld_rd_r <= cvld_r[cnt_raddr];
  end

`ifndef SYNTHESIS
  a_ok_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK) |-> $past(state_r == S_DR2))
    else $error("ok result without a walk step");

  a_drain_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_DRAIN && flags_r == 2'b00 && rem_r != '0)
      |=> (state_r == S_DR1))
    else $error("pending drain did not start a walk");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(loaded_r) <= 32'(BLOCK_MAX))
    else $error("load count beyond capacity");

  a_cnt_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT) |=> (state_r == S_IDLE || state_r == S_PFX))
    else $error("bad exit from count write back");
`endif

endmodule

@@ hdl/ibwt_ram.sv @@
module ibwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
